@@ rtl/core/mbd_pkg.sv @@
// ============================================================================
// mbd_pkg
// Shared types, sizes and helpers for the 2x2 box-filter mipmap reducer.
// ============================================================================
package mbd_pkg;

  localparam int unsigned MAX_WIDTH    = 4096;
  localparam int unsigned HEIGHT_LIMIT = 4096;
  localparam int unsigned LINE_DEPTH   = MAX_WIDTH / 2;
  localparam int unsigned LINE_AW      = $clog2(LINE_DEPTH);

  localparam int unsigned CFG_W  = 13;
  localparam int unsigned W_W    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned H_W    = $clog2(HEIGHT_LIMIT + 1);
  localparam int unsigned ROW_W  = $clog2(HEIGHT_LIMIT);

  localparam int unsigned CH_W   = 8;
  localparam int unsigned PAIR_W = CH_W + 1;
  localparam int unsigned QUAD_W = CH_W + 2;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_EMIT  = 1'b1
  } op_kind_e;

  typedef struct packed {
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_alpha;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
    logic            frame_last;
  } mip_t;

  typedef struct packed {
    logic [PAIR_W-1:0] red;
    logic [PAIR_W-1:0] green;
    logic [PAIR_W-1:0] blue;
    logic [PAIR_W-1:0] alpha;
  } pair_t;

  typedef struct packed {
    op_kind_e           op;
    logic [LINE_AW-1:0] idx;
    pair_t              pair;
    logic               last;
  } q_entry_t;

  function automatic logic [W_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
    logic [W_W-1:0] r;
    if (v == '0) begin
      r = W_W'(1);
    end else if (int'(v) > int'(MAX_WIDTH)) begin
      r = W_W'(MAX_WIDTH);
    end else begin
      r = W_W'(v);
    end
    return r;
  endfunction

  function automatic logic [H_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
    logic [H_W-1:0] r;
    if (v == '0) begin
      r = H_W'(1);
    end else if (int'(v) > int'(HEIGHT_LIMIT)) begin
      r = H_W'(HEIGHT_LIMIT);
    end else begin
      r = H_W'(v);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/mbd_front.sv @@
// ============================================================================
// mbd_front
// Frame position tracking, left pixel hold and horizontal pair sums; queues
// a store for even-row pairs and an emit for odd-row pairs.
// ============================================================================
module mbd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [mbd_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  mbd_pkg::pixel_t           in_pixel_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output mbd_pkg::q_entry_t         q_entry_o
);

  logic [mbd_pkg::W_W-1:0]   width_q, width_d;
  logic [mbd_pkg::H_W-1:0]   height_q, height_d;
  logic [mbd_pkg::COL_W-1:0] col_q, col_d;
  logic [mbd_pkg::ROW_W-1:0] row_q, row_d;
  mbd_pkg::pixel_t           left_q, left_d;

  logic                      accept;
  logic [mbd_pkg::W_W-1:0]   col_next;
  logic [mbd_pkg::H_W-1:0]   row_next;
  logic [mbd_pkg::W_W-1:0]   width_even;
  logic [mbd_pkg::H_W-1:0]   height_even;
  logic                      in_block;
  logic                      restart;

  assign in_ready_o  = !q_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign col_next    = mbd_pkg::W_W'(col_q) + mbd_pkg::W_W'(1);
  assign row_next    = mbd_pkg::H_W'(row_q) + mbd_pkg::H_W'(1);
  assign width_even  = {width_q[mbd_pkg::W_W-1:1], 1'b0};
  assign height_even = {height_q[mbd_pkg::H_W-1:1], 1'b0};
  assign in_block    = col_q[0] && (col_next <= width_even) && (row_next <= height_even);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    restart  = 1'b0;
    if (cfg_we_i) begin
      case (mbd_pkg::cfg_reg_e'(cfg_index_i))
        mbd_pkg::CFG_SRC_WIDTH: begin
          width_d = mbd_pkg::clamp_width(cfg_data_i);
          restart = 1'b1;
        end
        mbd_pkg::CFG_SRC_HEIGHT: begin
          height_d = mbd_pkg::clamp_height(cfg_data_i);
          restart = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    left_d = left_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (!col_q[0]) begin
        left_d = in_pixel_i;
      end
      if (col_next >= width_q) begin
        col_d = '0;
        row_d = (row_next >= height_q) ? '0 : mbd_pkg::ROW_W'(row_next);
      end else begin
        col_d = mbd_pkg::COL_W'(col_next);
      end
    end
  end

  always_comb begin
    q_push_o             = accept && !restart && in_block;
    q_entry_o.op         = row_q[0] ? mbd_pkg::OP_EMIT : mbd_pkg::OP_STORE;
    q_entry_o.idx        = col_q[mbd_pkg::COL_W-1:1];
    q_entry_o.pair.red   = mbd_pkg::PAIR_W'(left_q.in_red)   + mbd_pkg::PAIR_W'(in_pixel_i.in_red);
    q_entry_o.pair.green = mbd_pkg::PAIR_W'(left_q.in_green) + mbd_pkg::PAIR_W'(in_pixel_i.in_green);
    q_entry_o.pair.blue  = mbd_pkg::PAIR_W'(left_q.in_blue)  + mbd_pkg::PAIR_W'(in_pixel_i.in_blue);
    q_entry_o.pair.alpha = mbd_pkg::PAIR_W'(left_q.in_alpha) + mbd_pkg::PAIR_W'(in_pixel_i.in_alpha);
    q_entry_o.last       = (col_next == width_even) && (row_next == height_even);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mbd_pkg::W_W'(mbd_pkg::MAX_WIDTH);
      height_q <= mbd_pkg::H_W'(mbd_pkg::HEIGHT_LIMIT);
      col_q    <= '0;
      row_q    <= '0;
      left_q   <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      left_q   <= left_d;
    end
  end

endmodule

@@ rtl/core/mbd_queue.sv @@
// ============================================================================
// mbd_queue
// Small register FIFO between the front and the back.
// ============================================================================
module mbd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mbd_pkg::q_entry_t entry_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output mbd_pkg::q_entry_t entry_o
);

  mbd_pkg::q_entry_t            slot_q [mbd_pkg::QUEUE_DEPTH];
  logic [mbd_pkg::QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [mbd_pkg::QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [mbd_pkg::QUEUE_AW:0]   count_q, count_d;

  assign full_o  = (count_q == (mbd_pkg::QUEUE_AW+1)'(mbd_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + mbd_pkg::QUEUE_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + mbd_pkg::QUEUE_AW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (mbd_pkg::QUEUE_AW+1)'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - (mbd_pkg::QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ rtl/core/mbd_back.sv @@
// ============================================================================
// mbd_back
// Line store of pair sums, vertical add and output register.
// ============================================================================
module mbd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  mbd_pkg::q_entry_t q_entry_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mbd_pkg::mip_t     out_pixel_o
);

  mbd_pkg::pair_t line_mem [mbd_pkg::LINE_DEPTH];

  mbd_pkg::pair_t rd_q;
  mbd_pkg::pair_t pair_q;
  logic           last_q;
  logic           s1_v_q, s1_v_d;
  logic           out_v_q, out_v_d;
  mbd_pkg::mip_t  out_q;

  logic                        out_free;
  logic                        s1_free;
  logic                        is_emit;
  logic                        pop_emit;
  logic [mbd_pkg::QUAD_W-1:0]  sum_r, sum_g, sum_b, sum_a;

  assign out_free = !out_v_q || out_ready_i;
  assign s1_free  = !s1_v_q || out_free;
  assign is_emit  = (q_entry_i.op == mbd_pkg::OP_EMIT);
  assign q_pop_o  = q_valid_i && (!is_emit || s1_free);
  assign pop_emit = q_pop_o && is_emit;

  assign sum_r = mbd_pkg::QUAD_W'(rd_q.red)   + mbd_pkg::QUAD_W'(pair_q.red);
  assign sum_g = mbd_pkg::QUAD_W'(rd_q.green) + mbd_pkg::QUAD_W'(pair_q.green);
  assign sum_b = mbd_pkg::QUAD_W'(rd_q.blue)  + mbd_pkg::QUAD_W'(pair_q.blue);
  assign sum_a = mbd_pkg::QUAD_W'(rd_q.alpha) + mbd_pkg::QUAD_W'(pair_q.alpha);

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      if (is_emit) begin
        rd_q <= line_mem[q_entry_i.idx];
      end else begin
        line_mem[q_entry_i.idx] <= q_entry_i.pair;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_emit) begin
      pair_q <= q_entry_i.pair;
      last_q <= q_entry_i.last;
    end
    if (out_free && s1_v_q) begin
      out_q.out_red    <= sum_r[mbd_pkg::QUAD_W-1:2];
      out_q.out_green  <= sum_g[mbd_pkg::QUAD_W-1:2];
      out_q.out_blue   <= sum_b[mbd_pkg::QUAD_W-1:2];
      out_q.out_alpha  <= sum_a[mbd_pkg::QUAD_W-1:2];
      out_q.frame_last <= last_q;
    end
  end

  always_comb begin
    out_v_d = out_free ? s1_v_q : out_v_q;
    if (pop_emit) begin
      s1_v_d = 1'b1;
    end else begin
      s1_v_d = out_free ? 1'b0 : s1_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_pixel_o = out_q;

  // a pending sum whose output slot is busy keeps its line store read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !out_free |=> $stable(rd_q) && s1_v_q)
    else $error("mbd_back: stalled sum lost its line store data");

  // a ready sum moves to the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && out_free |=> out_v_q)
    else $error("mbd_back: sum dropped on its way to the output");

  // an emit pulled from the queue is held for the add
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_emit |=> s1_v_q)
    else $error("mbd_back: emit popped without a pending sum");

endmodule

@@ rtl/core/mipmap_box_downsample_unit.sv @@
// ============================================================================
// mipmap_box_downsample_unit
// 2x2 box-filter mipmap reduction for an RGBA8 raster pixel stream.
// ============================================================================
// Usage:
//   Source pixels enter on in_valid_i/in_ready_o in raster order for a frame
//   of src_width x src_height (registers 0 and 1 on the cfg_* write port,
//   written while the block is idle; a write restarts the frame). Each
//   complete 2x2 block gives one half-size pixel on out_valid_o/out_ready_i,
//   each channel the floor of the four-sample average. frame_last marks the
//   last pixel of the half-size frame. Odd trailing columns/rows are dropped.
//   Throughput: one source pixel per clock, sustained while out_ready_i stays high.
//   Path: the odd-row pixel completing a block is registered in the queue, then
//   in the line store read register, then in the output after the add; a stall can hold it.
//   The line store is 2048 x 36 bits; at most one access per cycle, a write
//   for an even-row pair or a read for an odd-row pair.
//   A stalled receiver backs up the output register, the pending sum, then the
//   four-entry queue; in_ready_o drops only when that queue is full.
//   Reset: size 4096 x 4096, position at the frame start, no item pending.
//   The line store needs no clearing; each entry is written before it is read.
// ============================================================================
module mipmap_box_downsample_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [mbd_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  mbd_pkg::pixel_t           in_pixel_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output mbd_pkg::mip_t             out_pixel_o
);

  logic              q_push;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  mbd_pkg::q_entry_t q_entry_in;
  mbd_pkg::q_entry_t q_entry_out;

  mbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_pixel_i  (in_pixel_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_entry_in)
  );

  mbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (q_entry_out)
  );

  mbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pixel_o (out_pixel_o)
  );

endmodule
